### hw/rtl/tkd_pkg.sv
package tkd_pkg;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 1;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_ROWS = 1'b0,
    CFG_SCREEN_COLS = 1'b1
  } cfg_idx_e;

  localparam logic [7:0] RowsReset = 8'd24;
  localparam logic [7:0] ColsReset = 8'd80;

  // Sequence decoder phases
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_ESC   = 3'd1,
    PH_CSI   = 3'd2,
    PH_SS3   = 3'd3,
    PH_OTHER = 3'd4,
    PH_DIGIT = 3'd5
  } phase_e;

  // Decoded key kinds
  typedef enum logic [3:0] {
    K_PLAIN = 4'd0,
    K_LEFT  = 4'd1,
    K_RIGHT = 4'd2,
    K_UP    = 4'd3,
    K_DOWN  = 4'd4,
    K_HOME  = 4'd5,
    K_END   = 4'd6,
    K_DEL   = 4'd7,
    K_PGUP  = 4'd8,
    K_PGDN  = 4'd9
  } key_kind_e;

  localparam logic [7:0] ChEsc   = 8'h1b;
  localparam logic [7:0] ChBrack = 8'h5b; // '['
  localparam logic [7:0] ChO     = 8'h4f; // 'O'
  localparam logic [7:0] ChTilde = 8'h7e; // '~'
  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChH     = 8'h48;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;
  localparam logic [7:0] ChQuit  = 8'h11; // ctrl-Q

  // Decoded key event, decoder -> cursor stage
  typedef struct packed {
    logic      valid;
    key_kind_e kind;
    logic [7:0] kbyte;
  } key_ev_t;

  // Finished result, cursor stage -> output port
  typedef struct packed {
    logic      valid;
    key_kind_e kind;
    logic [7:0] kbyte;
    logic [7:0] x;
    logic [7:0] y;
    logic      quit;
  } key_res_t;

endpackage

### hw/rtl/tkd_decode.sv
module tkd_decode import tkd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,     // stage may advance
  input  logic       accept_i,   // input transaction this cycle
  input  logic       timeout_i,
  input  logic [7:0] rx_byte_i,
  output key_ev_t    ev_o,
  output phase_e     phase_o
);

  phase_e     phase_q, phase_d;
  logic [7:0] held_q, held_d;
  key_ev_t    ev_q, ev_d;

  function automatic key_kind_e letter_key(input logic [7:0] b);
    key_kind_e k;
    unique case (b)
      ChA:     k = K_UP;
      ChB:     k = K_DOWN;
      ChC:     k = K_RIGHT;
      ChD:     k = K_LEFT;
      ChH:     k = K_HOME;
      ChF:     k = K_END;
      default: k = K_PLAIN;
    endcase
    return k;
  endfunction

  function automatic key_kind_e digit_key(input logic [7:0] d);
    key_kind_e k;
    unique case (d)
      8'h31, 8'h37: k = K_HOME;
      8'h33:        k = K_DEL;
      8'h34, 8'h38: k = K_END;
      8'h35:        k = K_PGUP;
      8'h36:        k = K_PGDN;
      default:      k = K_PLAIN;
    endcase
    return k;
  endfunction

  always_comb begin
    phase_d     = phase_q;
    held_d      = held_q;
    ev_d.valid  = 1'b0;
    ev_d.kind   = K_PLAIN;
    ev_d.kbyte  = ChEsc;
    if (accept_i) begin
      if (phase_q == PH_IDLE || phase_q > PH_DIGIT) begin
        phase_d = PH_IDLE;
        if (!timeout_i) begin
          if (rx_byte_i == ChEsc) begin
            phase_d = PH_ESC;
          end else begin
            ev_d.valid = 1'b1;
            ev_d.kbyte = rx_byte_i;
          end
        end
      end else if (timeout_i) begin
        phase_d    = PH_IDLE;
        ev_d.valid = 1'b1;
      end else begin
        unique case (phase_q)
          PH_ESC: begin
            if (rx_byte_i == ChBrack)  phase_d = PH_CSI;
            else if (rx_byte_i == ChO) phase_d = PH_SS3;
            else                       phase_d = PH_OTHER;
          end
          PH_CSI: begin
            if (rx_byte_i >= Ch0 && rx_byte_i <= Ch9) begin
              held_d  = rx_byte_i;
              phase_d = PH_DIGIT;
            end else begin
              phase_d    = PH_IDLE;
              ev_d.valid = 1'b1;
              ev_d.kind  = letter_key(rx_byte_i);
            end
          end
          PH_SS3: begin
            phase_d    = PH_IDLE;
            ev_d.valid = 1'b1;
            if (rx_byte_i == ChH)      ev_d.kind = K_HOME;
            else if (rx_byte_i == ChF) ev_d.kind = K_END;
          end
          PH_DIGIT: begin
            phase_d    = PH_IDLE;
            ev_d.valid = 1'b1;
            if (rx_byte_i == ChTilde) ev_d.kind = digit_key(held_q);
          end
          default: begin
            phase_d    = PH_IDLE;
            ev_d.valid = 1'b1;
          end
        endcase
      end
      // non-plain keys carry no byte
      if (ev_d.kind != K_PLAIN) ev_d.kbyte = 8'h00;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      held_q  <= 8'h00;
      ev_q    <= '0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      if (load_i) ev_q <= ev_d;
    end
  end

  assign ev_o    = ev_q;
  assign phase_o = phase_q;

endmodule

### hw/rtl/tkd_cursor.sv
module tkd_cursor import tkd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       load_i,    // output register free or being drained
  input  key_ev_t    ev_i,
  input  logic [7:0] rows_i,
  input  logic [7:0] cols_i,
  output key_res_t   res_o
);

  logic [7:0] col_q, line_q;
  logic [7:0] max_x, max_y, cx, cy, nx, ny;
  key_res_t   res_q;

  always_comb begin
    max_x = (cols_i == 8'd0) ? 8'd0 : cols_i - 8'd1;
    max_y = (rows_i == 8'd0) ? 8'd0 : rows_i - 8'd1;
    // pull the cursor back inside a screen that shrank
    cx = (col_q > max_x) ? max_x : col_q;
    cy = (line_q > max_y) ? max_y : line_q;
    nx = cx;
    ny = cy;
    case (ev_i.kind)
      K_LEFT:  if (cx != 8'd0) nx = cx - 8'd1;
      K_RIGHT: if (cx < max_x) nx = cx + 8'd1;
      K_UP:    if (cy != 8'd0) ny = cy - 8'd1;
      K_DOWN:  if (cy < max_y) ny = cy + 8'd1;
      K_HOME:  nx = 8'd0;
      K_END:   nx = max_x;
      K_PGUP:  ny = 8'd0;
      K_PGDN:  ny = max_y;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q  <= 8'd0;
      line_q <= 8'd0;
      res_q  <= '0;
    end else if (load_i) begin
      res_q.valid <= ev_i.valid;
      if (ev_i.valid) begin
        col_q       <= nx;
        line_q      <= ny;
        res_q.kind  <= ev_i.kind;
        res_q.kbyte <= ev_i.kbyte;
        res_q.x     <= nx;
        res_q.y     <= ny;
        res_q.quit  <= (ev_i.kind == K_PLAIN) && (ev_i.kbyte == ChQuit);
      end
    end
  end

  assign res_o = res_q;

endmodule

### hw/rtl/terminal_key_decoder_cursor_unit.sv
// Channel  | Signals                 | Payload (lowest bit first)
// s_axis   | tvalid tready tdata tuser | tdata: rx_byte[7:0]; tuser: action
// m_axis   | tvalid tready tdata tuser | tdata: key_byte, cursor_x, cursor_y,
//          |                          |   quit_request, zero pad; tuser: key_kind
// cfg      | cfg_we cfg_idx cfg_data  | 0 screen_rows, 1 screen_cols
//
// One transaction per cycle sustained while m_axis is not stalled. From input
// acceptance a result passes the decode register, then the cursor/result register.
// Reset (rst_ni low, async) returns to no pending sequence, cursor at 0,0,
// 24 rows by 80 columns. A stall on m_axis backs up through both registers;
// s_axis_tready_o drops only when both hold data.
module terminal_key_decoder_cursor_unit import tkd_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input bytes / timeouts
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  logic [7:0]         s_axis_tdata_i,   // [7:0] rx_byte
  input  logic               s_axis_tuser_i,   // [0] action (1 = read timeout)
  // decoded keys
  output logic               m_axis_tvalid_o,
  input  logic               m_axis_tready_i,
  output logic [31:0]        m_axis_tdata_o,   // [7:0] key_byte, [15:8] cursor_x,
                                               // [23:16] cursor_y, [24] quit_request
  output logic [3:0]         m_axis_tuser_o,   // [3:0] key_kind
  // configuration
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i
);

  logic       rows_we, cols_we;
  logic [7:0] rows_q, cols_q;
  logic       out_en, dec_en, in_acc;
  key_ev_t    ev;
  key_res_t   res;
  phase_e     phase;

  // config registers
  always_comb begin
    rows_we = 1'b0;
    cols_we = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_ROWS: rows_we = 1'b1;
        CFG_SCREEN_COLS: cols_we = 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= RowsReset;
      cols_q <= ColsReset;
    end else begin
      if (rows_we) rows_q <= cfg_data_i;
      if (cols_we) cols_q <= cfg_data_i;
    end
  end

  // pipeline advance: each register moves when the one after it frees up
  assign out_en          = !res.valid || m_axis_tready_i;
  assign dec_en          = !ev.valid || out_en;
  assign s_axis_tready_o = dec_en;
  assign in_acc          = s_axis_tvalid_i && dec_en;

  tkd_decode u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .load_i    (dec_en),
    .accept_i  (in_acc),
    .timeout_i (s_axis_tuser_i),
    .rx_byte_i (s_axis_tdata_i),
    .ev_o      (ev),
    .phase_o   (phase)
  );

  tkd_cursor u_cursor (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (out_en),
    .ev_i   (ev),
    .rows_i (rows_q),
    .cols_i (cols_q),
    .res_o  (res)
  );

  assign m_axis_tvalid_o = res.valid;
  assign m_axis_tuser_o  = res.kind;
  assign m_axis_tdata_o  = {7'd0, res.quit, res.y, res.x, res.kbyte};

`ifndef ASSERT_OFF
  // a decoded key waiting behind a stalled output must not be lost
  a_ev_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ev.valid && !out_en |=> ev.valid)
    else $error("decoded key dropped under stall");

  // a timeout with nothing pending yields no key
  a_idle_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && s_axis_tuser_i && phase == PH_IDLE |=> !ev.valid)
    else $error("key produced from idle timeout");

  // an ESC byte from idle only opens a sequence
  a_esc_opens: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && !s_axis_tuser_i && phase == PH_IDLE && s_axis_tdata_i == ChEsc
    |=> !ev.valid && phase == PH_ESC)
    else $error("ESC did not open a sequence");

  // non-plain keys carry a zero byte and never request quit
  a_nonplain_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res.valid && res.kind != K_PLAIN |-> res.kbyte == 8'h00 && !res.quit)
    else $error("non-plain key with byte or quit");
`endif

endmodule

### bench/terminal_key_decoder_cursor_unit_tb.sv
`timescale 1ns / 1ps

module terminal_key_decoder_cursor_unit_tb;
  import tkd_pkg::*;

  // Cycles to let an in-flight item (one that may produce no key) clear both
  // pipeline registers before we touch the config port or finish.
  localparam int DrainCycles = 6;

  typedef struct {
    key_kind_e  kind;
    logic [7:0] kbyte;
    logic [7:0] x;
    logic [7:0] y;
    logic       quit;
  } key_exp_t;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               s_axis_tvalid_i = 1'b0;
  logic               s_axis_tready_o;
  logic [7:0]         s_axis_tdata_i = '0;
  logic               s_axis_tuser_i = 1'b0;
  logic               m_axis_tvalid_o;
  logic               m_axis_tready_i = 1'b0;
  logic [31:0]        m_axis_tdata_o;
  logic [3:0]         m_axis_tuser_o;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [7:0]         cfg_data_i = '0;

  // Shadow of the block: screen size, sequence decoder and cursor
  logic [7:0] rows_q = RowsReset;
  logic [7:0] cols_q = ColsReset;
  phase_e     phase_q = PH_IDLE;
  logic [7:0] held_q = '0;
  logic [7:0] col_q = '0;
  logic [7:0] line_q = '0;

  key_exp_t expected_keys[$];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_len = 0;       // pending receiver hold-off, in cycles
  int items_sent = 0;
  int keys_checked = 0;
  int screen_writes = 0;
  int mismatch_count = 0;
  bit kind_hit[10];

  always #2 clk_i = ~clk_i;

  terminal_key_decoder_cursor_unit dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),   // [7:0] rx_byte
    .s_axis_tuser_i (s_axis_tuser_i),   // [0] action
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),   // [7:0] key_byte, [15:8] x, [23:16] y, [24] quit
    .m_axis_tuser_o (m_axis_tuser_o),   // [3:0] key_kind
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Key/cursor predictor
  // ---------------------------------------------------------------------------

  // Finish a key: clamp the cursor to the current screen (size 0 acts as 1),
  // then apply the move and queue the expected output.
  function automatic void finish_key(key_kind_e kind, logic [7:0] b);
    logic [7:0] max_x;
    logic [7:0] max_y;
    logic [7:0] x;
    logic [7:0] y;
    key_exp_t   e;
    max_y = (rows_q == 8'd0) ? 8'd0 : rows_q - 8'd1;
    max_x = (cols_q == 8'd0) ? 8'd0 : cols_q - 8'd1;
    x = (col_q > max_x) ? max_x : col_q;
    y = (line_q > max_y) ? max_y : line_q;
    case (kind)
      K_LEFT:  if (x != 8'd0) x = x - 8'd1;
      K_RIGHT: if (x < max_x) x = x + 8'd1;
      K_UP:    if (y != 8'd0) y = y - 8'd1;
      K_DOWN:  if (y < max_y) y = y + 8'd1;
      K_HOME:  x = 8'd0;
      K_END:   x = max_x;
      K_PGUP:  y = 8'd0;
      K_PGDN:  y = max_y;
      default: ;
    endcase
    col_q   = x;
    line_q  = y;
    phase_q = PH_IDLE;
    e.kind  = kind;
    e.kbyte = (kind == K_PLAIN) ? b : 8'd0;
    e.x     = x;
    e.y     = y;
    e.quit  = (kind == K_PLAIN) && (b == ChQuit);
    expected_keys.push_back(e);
  endfunction

  // One accepted transaction into the sequence decoder.
  function automatic void decode_input(logic timeout, logic [7:0] b);
    key_kind_e k;
    if (phase_q == PH_IDLE) begin
      // timeout with nothing pending is dropped silently
      if (!timeout) begin
        if (b == ChEsc) phase_q = PH_ESC;
        else finish_key(K_PLAIN, b);
      end
    end else if (timeout) begin
      finish_key(K_PLAIN, ChEsc);
    end else begin
      case (phase_q)
        PH_ESC: begin
          phase_q = (b == ChBrack) ? PH_CSI : (b == ChO) ? PH_SS3 : PH_OTHER;
        end
        PH_CSI: begin
          if (b >= Ch0 && b <= Ch9) begin
            held_q  = b;
            phase_q = PH_DIGIT;
          end else begin
            case (b)
              ChA:     k = K_UP;
              ChB:     k = K_DOWN;
              ChC:     k = K_RIGHT;
              ChD:     k = K_LEFT;
              ChH:     k = K_HOME;
              ChF:     k = K_END;
              default: k = K_PLAIN;
            endcase
            finish_key(k, ChEsc);
          end
        end
        PH_SS3: begin
          k = (b == ChH) ? K_HOME : (b == ChF) ? K_END : K_PLAIN;
          finish_key(k, ChEsc);
        end
        PH_DIGIT: begin
          k = K_PLAIN;
          if (b == ChTilde) begin
            // ESC [ n ~ : 1,7 home; 3 delete; 4,8 end; 5 page up; 6 page down
            case (held_q)
              Ch0 + 8'd1, Ch0 + 8'd7: k = K_HOME;
              Ch0 + 8'd3:             k = K_DEL;
              Ch0 + 8'd4, Ch0 + 8'd8: k = K_END;
              Ch0 + 8'd5:             k = K_PGUP;
              Ch0 + 8'd6:             k = K_PGDN;
              default:                k = K_PLAIN;
            endcase
          end
          finish_key(k, ChEsc);
        end
        default: finish_key(K_PLAIN, ChEsc);  // ESC + unknown byte, second byte taken
      endcase
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Output side: random stall or hold-off, and the key checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (hold_len > 0) begin
      m_axis_tready_i <= 1'b0;
      hold_len = hold_len - 1;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, name, want, want, got, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk_i) begin
    key_exp_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      if (expected_keys.size() == 0) begin
        $display("%0t: unexpected key, expected none, actual kind %0d data 0x%08h",
                 $time, m_axis_tuser_o, m_axis_tdata_o);
        mismatch_count++;
      end else begin
        want = expected_keys.pop_front();
        check_field("key_kind", want.kind, m_axis_tuser_o);
        check_field("key_byte", want.kbyte, m_axis_tdata_o[7:0]);
        check_field("cursor_x", want.x, m_axis_tdata_o[15:8]);
        check_field("cursor_y", want.y, m_axis_tdata_o[23:16]);
        check_field("quit_request", want.quit, m_axis_tdata_o[24]);
        kind_hit[want.kind] = 1'b1;
        keys_checked++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------

  // Offer one transaction, with random idle cycles ahead of it. tvalid is
  // left high after acceptance; the next call or settle_block drops it.
  task automatic send_item(input logic timeout, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= timeout;
    s_axis_tdata_i  <= b;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    decode_input(timeout, b);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(1'b0, b);
  endtask

  // Timeout: byte lane carries junk, it must be ignored.
  task automatic send_timeout();
    logic [7:0] junk;
    junk = 8'($urandom);
    send_item(1'b1, junk);
  endtask

  task automatic send_csi(input logic [7:0] b);
    send_byte(ChEsc);
    send_byte(ChBrack);
    send_byte(b);
  endtask

  task automatic send_csi_digit(input logic [7:0] digit, input logic [7:0] b);
    send_csi(digit);
    send_byte(b);
  endtask

  // Stop offering, wait for every queued key, then let any trailing
  // no-result item fall out of the pipeline.
  task automatic settle_block();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (expected_keys.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [7:0] val);
    settle_block();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_SCREEN_ROWS) rows_q = val;
    else cols_q = val;
    screen_writes++;
  endtask

  task automatic set_screen(input logic [7:0] rows, input logic [7:0] cols);
    write_reg(CFG_SCREEN_ROWS, rows);
    write_reg(CFG_SCREEN_COLS, cols);
  endtask

  // Mostly small screens so clamping at the edges happens often.
  function automatic logic [7:0] pick_screen_dim();
    case ($urandom_range(5))
      0:       return 8'd1;
      1:       return 8'd2;
      2:       return 8'($urandom_range(3, 10));
      3:       return 8'($urandom_range(1, 255));
      4:       return 8'd255;
      default: return 8'($urandom_range(11, 80));
    endcase
  endfunction

  // One random key: mostly well-formed sequences, some broken ones and noise.
  task automatic send_random_key();
    int         pick;
    logic [7:0] digit;
    logic [7:0] rnd;
    logic [7:0] fin;
    pick  = $urandom_range(99);
    digit = Ch0 + 8'($urandom_range(9));
    rnd   = 8'($urandom);
    case ($urandom_range(5))
      0:       fin = ChA;
      1:       fin = ChB;
      2:       fin = ChC;
      3:       fin = ChD;
      4:       fin = ChH;
      default: fin = ChF;
    endcase
    if (pick < 20) begin
      send_byte(rnd);
    end else if (pick < 24) begin
      send_byte(ChQuit);
    end else if (pick < 48) begin
      send_csi(fin);
    end else if (pick < 56) begin
      send_byte(ChEsc);
      send_byte(ChO);
      send_byte($urandom_range(1) ? ChH : ChF);
    end else if (pick < 74) begin
      send_csi_digit(digit, ChTilde);
    end else if (pick < 78) begin
      send_timeout();
    end else if (pick < 82) begin
      send_byte(ChEsc);
      send_timeout();
    end else if (pick < 86) begin
      send_byte(ChEsc);
      send_byte(ChBrack);
      send_timeout();
    end else if (pick < 91) begin
      // digit sequence cut short or ended by the wrong byte
      send_csi(digit);
      if ($urandom_range(1)) send_timeout();
      else send_byte(rnd);
    end else if (pick < 96) begin
      send_byte(ChEsc);
      send_byte(rnd);
      rnd = 8'($urandom);
      send_byte(rnd);
    end else begin
      send_byte(ChEsc);
      send_byte($urandom_range(1) ? ChO : ChBrack);
      send_byte(rnd);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Byte extremes, quit, timeouts and the broken-sequence cases at 24x80.
  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(ChQuit);
    send_timeout();                              // idle timeout: no key
    send_byte(ChEsc);
    send_timeout();                              // pending ESC -> plain ESC
    send_byte(ChEsc);
    send_byte(ChO);
    send_byte(ChF);                              // end -> last column
    send_csi_digit(Ch0 + 8'd6, ChTilde);         // page down -> bottom row
    send_csi_digit(Ch0 + 8'd5, ChTilde);         // page up -> top row
    send_byte(ChEsc);
    send_byte(8'h78);                            // ESC + unknown: two bytes, one ESC
    send_byte(8'h79);
    send_csi_digit(Ch0 + 8'd2, ChTilde);         // unmapped digit
    send_csi_digit(Ch0 + 8'd3, 8'h7a);           // digit not closed by tilde
  endtask

  // Largest and smallest screens, shrinking under the cursor, size zero.
  task automatic test_screen_extremes();
    set_screen(8'd255, 8'd255);
    send_csi_digit(Ch0 + 8'd6, ChTilde);         // y -> 254
    send_csi_digit(Ch0 + 8'd4, ChTilde);         // x -> 254
    send_csi(ChC);                               // right at the edge stays
    set_screen(8'd10, 8'd5);
    send_byte(8'h61);                            // cursor clamped to 4,9
    send_csi_digit(Ch0 + 8'd3, ChTilde);         // delete: clamp only
    set_screen(8'd0, 8'd0);                      // zero acts as one
    send_csi(ChB);
    send_csi(ChC);
    set_screen(8'd1, 8'd1);
    send_csi(ChA);
    send_csi(ChD);
    set_screen(RowsReset, ColsReset);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = items_sent + n;
    set_screen(pick_screen_dim(), pick_screen_dim());
    while (items_sent < target) begin
      if ($urandom_range(99) < 2) set_screen(pick_screen_dim(), pick_screen_dim());
      send_random_key();
    end
  endtask

  // Long receiver hold-off while the sender keeps offering, so the pipe
  // fills and tready drops; then a full pause and a second hold-off.
  task automatic test_backpressure();
    logic [7:0] b;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle_block();
    hold_len = 80;
    repeat (40) begin
      b = 8'($urandom);
      send_byte((b == ChEsc) ? ChQuit : b);
    end
    settle_block();
    hold_len = 30;
    repeat (20) send_random_key();
  endtask

  initial begin
    bit all_kinds;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_screen_extremes();
    test_random_traffic(0, 0, 450);
    test_random_traffic(57, 0, 450);
    test_random_traffic(0, 57, 450);
    test_random_traffic(36, 36, 450);
    test_backpressure();

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    settle_block();

    all_kinds = 1'b1;
    foreach (kind_hit[i]) all_kinds &= kind_hit[i];
    $display("Summary: %0d input transactions, %0d keys checked, %0d screen size writes",
             items_sent, keys_checked, screen_writes);
    $display("Summary: all ten key kinds seen: %s; idle/stall mixes and a long hold-off run",
             all_kinds ? "yes" : "no");
    if (mismatch_count == 0 && expected_keys.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of ~2000 transactions.
  initial begin
    #2ms;
    $display("Timeout with %0d keys still expected", expected_keys.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

### files.f
hw/rtl/tkd_pkg.sv
hw/rtl/tkd_decode.sv
hw/rtl/tkd_cursor.sv
hw/rtl/terminal_key_decoder_cursor_unit.sv
bench/terminal_key_decoder_cursor_unit_tb.sv
